### rtl/core/rwsg_pkg.sv
// shared constants, types and the quarter-wave cosine table of the waveform sample generator
package rwsg_pkg;

	localparam int DAC_BITS    = 10;
	localparam int MAX_PERIOD  = 1024;
	localparam int MIN_PERIOD  = 20;
	localparam int PHASE_SHIFT = 1;

	localparam int FULL_SCALE  = 4096;
	localparam int LEVEL_SHIFT = 28;
	localparam int TABLE_DEPTH = 1024;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

	localparam int PER_W   = 11;
	localparam int LVL_W   = 13;
	localparam int IDX_W   = 10;
	localparam int CODE_W  = 10;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 13;

	localparam logic [CFG_AW-1:0] REG_WAVE_TYPE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_PERIOD    = 3'd1;
	localparam logic [CFG_AW-1:0] REG_OFFSET    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_AMPLITUDE = 3'd3;

	typedef enum logic [1:0] {
		WAVE_COS    = 2'd0,
		WAVE_SQUARE = 2'd1,
		WAVE_SAW    = 2'd2,
		WAVE_TRI    = 2'd3
	} wave_t;

	typedef logic [15:0] cos_rom_t [TABLE_DEPTH];

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// entry j is round(32768*cos(pi*j/2048)) from a q30 taylor sum
	function automatic logic [15:0] taylor_cos(input int unsigned j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] rnd;
		x    = (PI_Q30 * 64'(j)) >> 11;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = 64'sd1 <<< 30;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		rnd = ($unsigned(sum) + (64'd1 << 14)) >> 15;
		if (rnd > 64'd32768) begin
			rnd = 64'd32768;
		end
		return rnd[15:0];
	endfunction

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			rom[j] = taylor_cos(j);
		end
		return rom;
	endfunction

	localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

### rtl/core/reference_waveform_sample_gen.sv
// waveform sample generator: sample index in, dac code out, pipelined divider and cosine rom
//
//  channel   signals                              transfer when
//  in        in_valid in_stall sample_index       in_valid && !in_stall
//  out       out_valid out_stall dac_code         out_valid && !out_stall
//            clipped index_error
//  config    cfg_we cfg_index cfg_data            cfg_we
//
// one index a cycle while out_stall is low; two setup stages, six divider stages of
// three restoring steps each, rom read, multiply, clamp and scale
// reset clears all valid bits and loads the register reset values
// each stage holds while the stage after it is full and stalled, so bubbles
// close up and in_stall rises only when every stage is occupied
module reference_waveform_sample_gen (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rwsg_pkg::CFG_AW-1:0]       cfg_index,
	input  logic [rwsg_pkg::CFG_DW-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rwsg_pkg::IDX_W-1:0]        sample_index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rwsg_pkg::CODE_W-1:0]       dac_code,
	output logic                              clipped,
	output logic                              index_error
);

	localparam int DIV_STAGES = 6;
	localparam int DIV_STEPS  = 3;
	localparam int QUO_W      = DIV_STAGES * DIV_STEPS;
	localparam int NUM_W      = 26;
	localparam int REM_W      = 10;
	localparam int DEN_W      = 11;
	localparam int W_W        = 17;
	localparam int MAXCODE    = (1 << rwsg_pkg::DAC_BITS) - 1;

	// configuration registers
	rwsg_pkg::wave_t                  wave_q;
	logic [rwsg_pkg::PER_W-1:0]       period_q;
	logic [rwsg_pkg::LVL_W-1:0]       offset_q;
	logic [rwsg_pkg::LVL_W-1:0]       ampl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q   <= rwsg_pkg::WAVE_COS;
			period_q <= rwsg_pkg::PER_W'(100);
			offset_q <= rwsg_pkg::LVL_W'(2048);
			ampl_q   <= rwsg_pkg::LVL_W'(2048);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rwsg_pkg::REG_WAVE_TYPE: wave_q   <= rwsg_pkg::wave_t'(cfg_data[1:0]);
				rwsg_pkg::REG_PERIOD:    period_q <= cfg_data[rwsg_pkg::PER_W-1:0];
				rwsg_pkg::REG_OFFSET:    offset_q <= cfg_data;
				rwsg_pkg::REG_AMPLITUDE: ampl_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated configuration; the user must keep it static while items are in flight, the block does not enforce it
	logic [rwsg_pkg::PER_W-1:0] n_sat;
	logic [rwsg_pkg::LVL_W-1:0] off_sat;
	logic [rwsg_pkg::LVL_W-1:0] amp_sat;

	always_comb begin
		if (period_q < rwsg_pkg::PER_W'(rwsg_pkg::MIN_PERIOD)) begin
			n_sat = rwsg_pkg::PER_W'(rwsg_pkg::MIN_PERIOD);
		end else if (period_q > rwsg_pkg::PER_W'(rwsg_pkg::MAX_PERIOD)) begin
			n_sat = rwsg_pkg::PER_W'(rwsg_pkg::MAX_PERIOD);
		end else begin
			n_sat = period_q;
		end
		off_sat = (offset_q > rwsg_pkg::LVL_W'(rwsg_pkg::FULL_SCALE)) ?
			rwsg_pkg::LVL_W'(rwsg_pkg::FULL_SCALE) : offset_q;
		amp_sat = (ampl_q > rwsg_pkg::LVL_W'(rwsg_pkg::FULL_SCALE)) ?
			rwsg_pkg::LVL_W'(rwsg_pkg::FULL_SCALE) : ampl_q;
	end

	// valid bits and flow control
	logic                  vld_s1, vld_s2, vld_s4, vld_s5, vld_s6;
	logic [DIV_STAGES-1:0] vld_s3;
	logic                  rdy_s1, rdy_s2, rdy_s4, rdy_s5, rdy_s6;
	logic [DIV_STAGES-1:0] rdy_s3;

	always_comb begin
		rdy_s6 = !vld_s6 || !out_stall;
		rdy_s5 = !vld_s5 || rdy_s6;
		rdy_s4 = !vld_s4 || rdy_s5;
		for (int i = DIV_STAGES - 1; i >= 0; i--) begin
			if (i == DIV_STAGES - 1) begin
				rdy_s3[i] = !vld_s3[i] || rdy_s4;
			end else begin
				rdy_s3[i] = !vld_s3[i] || rdy_s3[i+1];
			end
		end
		rdy_s2 = !vld_s2 || rdy_s3[0];
		rdy_s1 = !vld_s1 || rdy_s2;
	end

	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= '0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			for (int i = 0; i < DIV_STAGES; i++) begin
				if (rdy_s3[i]) begin
					vld_s3[i] <= (i == 0) ? vld_s2 : vld_s3[i-1];
				end
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3[DIV_STAGES-1];
			end
			if (rdy_s5) begin
				vld_s5 <= vld_s4;
			end
			if (rdy_s6) begin
				vld_s6 <= vld_s5;
			end
		end
	end

	// stage 1: range check and phase shift
	logic [rwsg_pkg::PER_W-1:0] p_in;
	logic [rwsg_pkg::PER_W-1:0] p_s1;
	logic                       err_s1;

	always_comb begin
		p_in = rwsg_pkg::PER_W'(sample_index) + rwsg_pkg::PER_W'(rwsg_pkg::PHASE_SHIFT);
		if (p_in >= n_sat) begin
			p_in = p_in - n_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			p_s1   <= p_in;
			err_s1 <= (rwsg_pkg::PER_W'(sample_index) >= n_sat);
		end
	end

	// stage 2: fold the shape into one division
	logic [11:0]       t_sh;
	logic [11:0]       k_sh;
	logic [11:0]       k_num;
	logic [NUM_W-1:0]  num_c;
	logic [DEN_W-1:0]  den_c;
	logic              sq_low_c;
	logic [DEN_W-1:0]  dm1;

	always_comb begin
		dm1      = n_sat - DEN_W'(1);
		t_sh     = '0;
		k_sh     = '0;
		k_num    = '0;
		sq_low_c = 1'b0;
		unique case (wave_q)
			rwsg_pkg::WAVE_SQUARE: begin
				t_sh     = 12'(p_s1) + 12'(n_sat >> 2);
				k_sh     = (t_sh >= 12'(n_sat)) ? t_sh - 12'(n_sat) : t_sh;
				sq_low_c = ((k_sh << 1) >= 12'(dm1));
				k_num    = k_sh;
			end
			rwsg_pkg::WAVE_SAW: begin
				t_sh  = 12'(p_s1) + 12'(n_sat) - 12'((12'(n_sat) + 12'd3) >> 2);
				k_sh  = (t_sh >= 12'(n_sat)) ? t_sh - 12'(n_sat) : t_sh;
				k_num = k_sh;
			end
			rwsg_pkg::WAVE_TRI: begin
				t_sh = 12'(p_s1) << 1;
				if (t_sh < 12'(n_sat)) begin
					k_sh  = t_sh;
					k_num = 12'(dm1) - t_sh;
				end else begin
					k_sh  = t_sh - 12'(n_sat);
					k_num = k_sh;
				end
			end
			default: begin
				t_sh  = '0;
				k_sh  = '0;
				k_num = '0;
			end
		endcase
		if (wave_q == rwsg_pkg::WAVE_COS) begin
			num_c = NUM_W'({p_s1, 12'd0}) + NUM_W'(n_sat >> 1);
			den_c = n_sat;
		end else begin
			num_c = NUM_W'({k_num[9:0], 16'd0}) + NUM_W'(dm1 >> 1);
			den_c = dm1;
		end
	end

	logic [REM_W-1:0] rem_s2;
	logic [QUO_W-1:0] nq_s2;
	logic [DEN_W-1:0] den_s2;
	logic             sq_s2;
	logic             err_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			rem_s2 <= REM_W'(num_c[NUM_W-1:QUO_W]);
			nq_s2  <= num_c[QUO_W-1:0];
			den_s2 <= den_c;
			sq_s2  <= sq_low_c;
			err_s2 <= err_s1;
		end
	end

	// stage 3: restoring divider, three quotient bits per stage
	logic [REM_W-1:0] rem_s3 [DIV_STAGES];
	logic [QUO_W-1:0] nq_s3  [DIV_STAGES];
	logic [DEN_W-1:0] den_s3 [DIV_STAGES];
	logic             sq_s3  [DIV_STAGES];
	logic             err_s3 [DIV_STAGES];
	logic [REM_W-1:0] rem_nx [DIV_STAGES];
	logic [QUO_W-1:0] nq_nx  [DIV_STAGES];

	always_comb begin
		logic [REM_W-1:0] r;
		logic [QUO_W-1:0] q;
		logic [DEN_W-1:0] d;
		logic [DEN_W:0]   sh;
		for (int i = 0; i < DIV_STAGES; i++) begin
			r = (i == 0) ? rem_s2 : rem_s3[i-1];
			q = (i == 0) ? nq_s2 : nq_s3[i-1];
			d = (i == 0) ? den_s2 : den_s3[i-1];
			for (int s = 0; s < DIV_STEPS; s++) begin
				sh = {1'b0, r, q[QUO_W-1]};
				q  = q << 1;
				if (sh >= {1'b0, d}) begin
					sh   = sh - {1'b0, d};
					q[0] = 1'b1;
				end
				r = sh[REM_W-1:0];
			end
			rem_nx[i] = r;
			nq_nx[i]  = q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			if (rdy_s3[i]) begin
				rem_s3[i] <= rem_nx[i];
				nq_s3[i]  <= nq_nx[i];
				den_s3[i] <= (i == 0) ? den_s2 : den_s3[i-1];
				sq_s3[i]  <= (i == 0) ? sq_s2 : sq_s3[i-1];
				err_s3[i] <= (i == 0) ? err_s2 : err_s3[i-1];
			end
		end
	end

	// stage 4: quadrant fold and cosine rom read
	logic [QUO_W-1:0]            quo;
	logic [1:0]                  quad;
	logic [rwsg_pkg::TABLE_AW:0] m_addr;

	always_comb begin
		quo  = nq_s3[DIV_STAGES-1];
		quad = quo[11:10];
		if (quad[0]) begin
			m_addr = (rwsg_pkg::TABLE_AW+1)'(rwsg_pkg::TABLE_DEPTH) -
				(rwsg_pkg::TABLE_AW+1)'(quo[9:0]);
		end else begin
			m_addr = (rwsg_pkg::TABLE_AW+1)'(quo[9:0]);
		end
	end

	logic [15:0]    rom_s4;
	logic           zero_s4;
	logic           neg_s4;
	logic [W_W-1:0] w_s4;
	logic           err_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			rom_s4  <= rwsg_pkg::COS_ROM[m_addr[rwsg_pkg::TABLE_AW-1:0]];
			zero_s4 <= m_addr[rwsg_pkg::TABLE_AW];
			neg_s4  <= (quad == 2'd1) || (quad == 2'd2);
			if (wave_q == rwsg_pkg::WAVE_SQUARE) begin
				w_s4 <= sq_s3[DIV_STAGES-1] ? '0 : W_W'(65536);
			end else begin
				w_s4 <= quo[W_W-1:0];
			end
			err_s4 <= err_s3[DIV_STAGES-1];
		end
	end

	// stage 5: amplitude multiply
	logic signed [17:0] opnd;
	logic signed [16:0] c_mag;

	always_comb begin
		c_mag = zero_s4 ? 17'sd0 : $signed({1'b0, rom_s4});
		if (wave_q == rwsg_pkg::WAVE_COS) begin
			opnd = neg_s4 ? -18'(c_mag) : 18'(c_mag);
		end else begin
			opnd = $signed({1'b0, w_s4});
		end
	end

	logic signed [31:0] prod_s5;
	logic signed [32:0] base_s5;
	logic               err_s5;

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			prod_s5 <= 32'($signed({1'b0, amp_sat}) * opnd);
			if (wave_q == rwsg_pkg::WAVE_COS) begin
				base_s5 <= $signed({4'd0, off_sat, 16'd0});
			end else begin
				base_s5 <= $signed({4'd0, off_sat, 16'd0}) - $signed({4'd0, amp_sat, 16'd0});
			end
			err_s5 <= err_s4;
		end
	end

	// stage 6: clamp and scale to the dac range
	logic signed [33:0] lvl;
	logic [28:0]        lvl_c;
	logic               clip_c;
	logic [39:0]        scaled;
	logic [39:0]        code_w;

	always_comb begin
		lvl    = 34'(base_s5) + (34'(prod_s5) <<< 1);
		clip_c = 1'b0;
		if (lvl < 0) begin
			lvl_c  = '0;
			clip_c = 1'b1;
		end else if (lvl > 34'sd268435456) begin
			lvl_c  = 29'd268435456;
			clip_c = 1'b1;
		end else begin
			lvl_c = lvl[28:0];
		end
		scaled = 40'(lvl_c) * 40'(MAXCODE);
		code_w = (scaled + (40'd1 << (rwsg_pkg::LEVEL_SHIFT - 1))) >> rwsg_pkg::LEVEL_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			if (err_s5) begin
				dac_code    <= '0;
				clipped     <= 1'b0;
				index_error <= 1'b1;
			end else begin
				dac_code    <= code_w[rwsg_pkg::CODE_W-1:0];
				clipped     <= clip_c;
				index_error <= 1'b0;
			end
		end
	end

	assign out_valid = vld_s6;

endmodule
